FILE: hdl/scs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants of the four-axis servo slew controller.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int WIDTH_W   = 15;
  localparam int AXES      = 4;
  localparam int NUM_REGS  = 2 * AXES;
  localparam int CFG_IDX_W = 4;
  localparam int CHAR_W    = 8;
  localparam int STEP_SIZE_DEFAULT = 10;

  localparam int AX_X    = 0;
  localparam int AX_Y    = 1;
  localparam int AX_Z    = 2;
  localparam int AX_CLAW = 3;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [WIDTH_W-1:0] width_t;
  typedef width_t [AXES-1:0] axes_t;
  typedef width_t [NUM_REGS-1:0] limits_t;

  typedef struct packed {
    logic   cmd_valid;
    logic   done_res;
    width_t claw_duty;
    width_t z_duty;
    width_t y_duty;
    width_t x_duty;
  } res_t;

  localparam int RES_W = $bits(res_t);
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  localparam axes_t OFF_POSE   = {15'd800, 15'd1000, 15'd1100, 15'd1600};
  localparam axes_t START_POSE = {15'd800, 15'd1800, 15'd1500, 15'd1600};
  localparam width_t MID_Y     = 15'd1500;

  localparam width_t LIMIT_LOW_RESET  = 15'd500;
  localparam width_t LIMIT_HIGH_RESET = 15'd2500;

  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CHAR_W-1:0] CH_OFF    = 8'h6F;  // 'o'
  localparam logic [CHAR_W-1:0] CH_START  = 8'h73;  // 's'
  localparam logic [CHAR_W-1:0] CH_CLAW   = 8'h63;  // 'c'
  localparam logic [CHAR_W-1:0] CH_Z      = 8'h64;  // 'd'
  localparam logic [CHAR_W-1:0] CH_Y      = 8'h66;  // 'f'
  localparam logic [CHAR_W-1:0] CH_X_LOW  = 8'h6C;  // 'l'
  localparam logic [CHAR_W-1:0] CH_X_HIGH = 8'h72;  // 'r'
  localparam logic [CHAR_W-1:0] CH_Y_MID  = 8'h6D;  // 'm'

endpackage

FILE: hdl/scs_axis_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_axis_step
// One slew step of a single axis toward its goal, clamped at the goal.
// ----------------------------------------------------------------------------
module scs_axis_step #(
  parameter int STEP_SIZE = scs_pkg::STEP_SIZE_DEFAULT
) (
  input  scs_pkg::width_t cur,
  input  scs_pkg::width_t goal,
  output scs_pkg::width_t stepped
);
  import scs_pkg::*;

  localparam width_t STEP = WIDTH_W'(STEP_SIZE);

  width_t diff_up;
  width_t diff_down;

  assign diff_up   = goal - cur;
  assign diff_down = cur - goal;

  always_comb begin
    priority if (cur < goal) begin
      stepped = (diff_up > STEP) ? cur + STEP : goal;
    end else if (cur > goal) begin
      stepped = (diff_down > STEP) ? cur - STEP : goal;
    end else begin
      stepped = cur;
    end
  end

endmodule

FILE: hdl/scs_cmd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_cmd_decode
// Decodes a command character into a new goal set for all four axes.
// ----------------------------------------------------------------------------
module scs_cmd_decode (
  input  logic [scs_pkg::CHAR_W-1:0] cmd_char,
  input  scs_pkg::axes_t             cur,
  input  scs_pkg::limits_t           limits,
  output scs_pkg::axes_t             goal_new,
  output logic                       hit
);
  import scs_pkg::*;

  width_t x_lo, x_hi, y_lo, y_hi, z_lo, z_hi, c_lo, c_hi;

  assign x_lo = limits[2 * AX_X];
  assign x_hi = limits[2 * AX_X + 1];
  assign y_lo = limits[2 * AX_Y];
  assign y_hi = limits[2 * AX_Y + 1];
  assign z_lo = limits[2 * AX_Z];
  assign z_hi = limits[2 * AX_Z + 1];
  assign c_lo = limits[2 * AX_CLAW];
  assign c_hi = limits[2 * AX_CLAW + 1];

  always_comb begin
    goal_new = cur;
    hit      = 1'b1;
    unique case (cmd_char)
      CH_OFF:    goal_new = OFF_POSE;
      CH_START:  goal_new = START_POSE;
      CH_CLAW:   goal_new[AX_CLAW] = (cur[AX_CLAW] == c_lo) ? c_hi : c_lo;
      CH_Z:      goal_new[AX_Z] = (cur[AX_Z] == z_hi) ? z_lo : z_hi;
      CH_Y:      goal_new[AX_Y] = (cur[AX_Y] == y_hi) ? y_lo : y_hi;
      CH_X_LOW:  goal_new[AX_X] = x_lo;
      CH_X_HIGH: goal_new[AX_X] = x_hi;
      CH_Y_MID:  goal_new[AX_Y] = MID_Y;
      default:   hit = 1'b0;
    endcase
  end

endmodule

FILE: hdl/scs_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_out_fifo
// Two-entry result buffer that decouples the update stage from the sink.
// ----------------------------------------------------------------------------
module scs_out_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  scs_pkg::res_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_ready,
  output scs_pkg::res_t out_data
);
  import scs_pkg::*;

  res_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  pop;

  assign full      = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("result buffer overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result buffer count out of range");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("buffered result changed while stalled");

endmodule

FILE: hdl/servo_command_slew_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_command_slew_controller
// Four-axis servo pulse-width slew controller: commands set goals, ticks
// step each axis toward its goal; one result per request.
// Each request passes through the input register, then the update and result
// buffer, before its result is offered; a full result buffer holds it in the
// input register.
// Throughput: one request per cycle unless the buffer is full; the two-entry
// result buffer keeps the input side moving while a finished result waits.
// Reset (synchronous, rst high): limits to 500/2500, current and goal widths
// to the off pose, pipeline and result buffer empty.
// ----------------------------------------------------------------------------
module servo_command_slew_controller #(
  parameter int STEP_SIZE = scs_pkg::STEP_SIZE_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [scs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scs_pkg::WIDTH_W-1:0]      cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [scs_pkg::CHAR_W-1:0]       s_axis_tdata,  // [7:0] cmd_char
  input  logic                             s_axis_tuser,  // [0] op
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [14:0] x_duty, [29:15] y_duty, [44:30] z_duty, [59:45] claw_duty,
  // [60] done_res, [61] cmd_valid, rest zero
  output logic [scs_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import scs_pkg::*;

  limits_t             limits;
  axes_t               cur;
  axes_t               goal;
  axes_t               cur_next;
  axes_t               goal_next;
  axes_t               stepped;
  axes_t               goal_cmd;
  logic                cmd_hit;

  logic                in_valid;
  logic                in_op;
  logic [CHAR_W-1:0]   in_char;
  logic                advance;
  logic                buf_full;
  res_t                res;
  res_t                out_res;

  assign advance       = in_valid && !buf_full;
  assign s_axis_tready = !in_valid || !buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits <= {AXES{LIMIT_HIGH_RESET, LIMIT_LOW_RESET}};
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      limits[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= s_axis_tuser;
      in_char <= s_axis_tdata;
    end
  end

  scs_cmd_decode u_decode (
    .cmd_char (in_char),
    .cur      (cur),
    .limits   (limits),
    .goal_new (goal_cmd),
    .hit      (cmd_hit)
  );

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    scs_axis_step #(
      .STEP_SIZE (STEP_SIZE)
    ) u_step (
      .cur     (cur[a]),
      .goal    (goal[a]),
      .stepped (stepped[a])
    );
  end

  always_comb begin
    cur_next  = cur;
    goal_next = goal;
    if (in_op == OP_TICK) begin
      cur_next = stepped;
    end else if (cmd_hit) begin
      goal_next = goal_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur  <= OFF_POSE;
      goal <= OFF_POSE;
    end else if (advance) begin
      cur  <= cur_next;
      goal <= goal_next;
    end
  end

  assign res.x_duty    = cur_next[AX_X];
  assign res.y_duty    = cur_next[AX_Y];
  assign res.z_duty    = cur_next[AX_Z];
  assign res.claw_duty = cur_next[AX_CLAW];
  assign res.done_res  = (cur_next == goal_next);
  assign res.cmd_valid = (in_op == OP_CMD) && cmd_hit;

  scs_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_data (res),
    .full      (buf_full),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = OUT_DATA_W'(out_res);

  a_tick_keeps_goal: assert property (@(posedge clk) disable iff (rst)
    (advance && in_op == OP_TICK) |=> $stable(goal))
    else $error("goal changed on a tick");

  a_cmd_keeps_current: assert property (@(posedge clk) disable iff (rst)
    (advance && in_op == OP_CMD) |=> $stable(cur))
    else $error("current width changed on a command");

  a_state_held_when_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(cur) && $stable(goal)))
    else $error("state changed without a request");

endmodule
